// ===== design/clhq_pkg.sv =====
// Shared types and constants of the CLH queue lock manager.
// No dependencies; compiled first.
package clhq_pkg;

    localparam int THREAD_W        = 4;
    localparam int NUM_THREADS_DEF = 16;

    typedef enum logic [0:0] {
        REQ_ACQUIRE = 1'b0,
        REQ_RELEASE = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WAIT = 2'd1,
        ST_HOLD = 2'd2
    } t_status;

    typedef struct packed {
        logic                grant_valid;
        logic [THREAD_W-1:0] grant_thread;
        logic                queued;
        logic                misuse;
    } t_result;

endpackage

// ===== design/clhq_if.sv =====
// Valid/ready channel interfaces for request and result items.
// Depends on clhq_pkg.
interface clhq_req_if;
    import clhq_pkg::*;
    logic                valid;
    logic                ready;
    t_req                req_type;
    logic [THREAD_W-1:0] req_thread;
    modport source (output valid, output req_type, output req_thread, input ready);
    modport sink   (input valid, input req_type, input req_thread, output ready);
endinterface

interface clhq_res_if;
    import clhq_pkg::*;
    logic                valid;
    logic                ready;
    logic                grant_valid;
    logic [THREAD_W-1:0] grant_thread;
    logic                queued;
    logic                misuse;
    modport source (output valid, output grant_valid, output grant_thread,
                    output queued, output misuse, input ready);
    modport sink   (input valid, input grant_valid, input grant_thread,
                    input queued, input misuse, output ready);
endinterface

// ===== design/clhq_core.sv =====
// Lock state of the CLH queue: node flags, thread nodes, predecessors,
// tail, waiter map and thread status. Depends on clhq_pkg.
module clhq_core #(
    parameter int NUM_THREADS = clhq_pkg::NUM_THREADS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  clhq_pkg::t_req                  i_req_type,
    input  logic [clhq_pkg::THREAD_W-1:0]   i_req_thread,
    output clhq_pkg::t_result               o_result
);
    import clhq_pkg::*;

    localparam int NODES  = NUM_THREADS + 1;
    localparam int NODE_W = $clog2(NODES);
    localparam int TID_W  = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int XW     = ((TID_W > THREAD_W) ? TID_W : THREAD_W) + 1;

    logic    [NODES-1:0]       r_flag,     n_flag;
    logic    [NODE_W-1:0]      r_node      [NUM_THREADS];
    logic    [NODE_W-1:0]      n_node      [NUM_THREADS];
    logic    [NODE_W-1:0]      r_pred      [NUM_THREADS];
    logic    [NODE_W-1:0]      r_tail,     n_tail;
    logic    [NODES-1:0]       r_wvalid,   n_wvalid;
    logic    [THREAD_W-1:0]    r_wthread   [NODES];
    t_status                   r_status    [NUM_THREADS];
    t_status                   n_status    [NUM_THREADS];

    logic [XW-1:0]     t_ext, w_ext;
    logic [TID_W-1:0]  t_idx, w_idx;
    logic              t_bad, w_bad;
    logic [NODE_W-1:0] cur_node, pred_node;
    logic [THREAD_W-1:0] w_thread;
    logic              pred_busy;
    logic              acq_ok, rel_ok;

    assign t_ext     = XW'(i_req_thread);
    assign t_idx     = t_ext[TID_W-1:0];
    assign t_bad     = t_ext >= XW'(NUM_THREADS);
    assign cur_node  = r_node[t_idx];
    assign pred_node = r_tail;
    assign pred_busy = (cur_node == pred_node) || r_flag[pred_node];
    assign w_thread  = r_wthread[cur_node];
    assign w_ext     = XW'(w_thread);
    assign w_idx     = w_ext[TID_W-1:0];
    assign w_bad     = w_ext >= XW'(NUM_THREADS);

    assign acq_ok = !t_bad && (i_req_type == REQ_ACQUIRE) && (r_status[t_idx] == ST_IDLE);
    assign rel_ok = !t_bad && (i_req_type == REQ_RELEASE) && (r_status[t_idx] == ST_HOLD);

    always_comb begin
        n_flag   = r_flag;
        n_node   = r_node;
        n_tail   = r_tail;
        n_wvalid = r_wvalid;
        n_status = r_status;
        o_result = '0;
        if (acq_ok) begin
            n_flag[cur_node] = 1'b1;
            n_tail           = cur_node;
            if (!pred_busy) begin
                n_status[t_idx]       = ST_HOLD;
                o_result.grant_valid  = 1'b1;
                o_result.grant_thread = i_req_thread;
            end else begin
                n_wvalid[pred_node] = 1'b1;
                n_status[t_idx]     = ST_WAIT;
                o_result.queued     = 1'b1;
            end
        end else if (rel_ok) begin
            n_flag[cur_node] = 1'b0;
            n_node[t_idx]    = r_pred[t_idx];
            n_status[t_idx]  = ST_IDLE;
            if (r_wvalid[cur_node]) begin
                n_wvalid[cur_node] = 1'b0;
                if (!w_bad) begin
                    n_status[w_idx] = ST_HOLD;
                end
                o_result.grant_valid  = 1'b1;
                o_result.grant_thread = w_thread;
            end
        end else begin
            o_result.misuse = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag   <= '0;
            r_tail   <= NODE_W'(NUM_THREADS);
            r_wvalid <= '0;
            for (int i = 0; i < NUM_THREADS; i++) begin
                r_node[i]   <= NODE_W'(i);
                r_status[i] <= ST_IDLE;
            end
        end else if (i_fire) begin
            r_flag   <= n_flag;
            r_tail   <= n_tail;
            r_wvalid <= n_wvalid;
            r_node   <= n_node;
            r_status <= n_status;
        end
    end

    // predecessor and waiter thread: payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_fire && acq_ok) begin
            r_pred[t_idx] <= pred_node;
            if (pred_busy) begin
                r_wthread[pred_node] <= i_req_thread;
            end
        end
    end

`ifndef SYNTH
    logic [NUM_THREADS-1:0] hold_vec;
    always_comb begin
        for (int i = 0; i < NUM_THREADS; i++) begin
            hold_vec[i] = (r_status[i] == ST_HOLD);
        end
    end

    a_single_holder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(hold_vec) <= 1)
        else $error("more than one thread holds the lock");

    a_misuse_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.misuse |-> !o_result.grant_valid && !o_result.queued)
        else $error("misuse item carries a grant or queue flag");

    a_queue_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.queued |-> !o_result.grant_valid)
        else $error("queued item also grants");

    a_tail_raised: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && acq_ok |=> r_flag[r_tail])
        else $error("tail node flag clear after acquire");
`endif

endmodule

// ===== design/clh_queue_lock_manager_unit.sv =====
// Top level of the CLH queue lock manager: input register, lock state,
// result register. Depends on clhq_pkg, clhq_if.sv and clhq_core.
//
//  channel  modport  payload                                        role
//  i_req    sink     req_type, req_thread                           lock requests
//  o_res    source   grant_valid, grant_thread, queued, misuse      one result per item
//
// One item per cycle while the result side is ready; an accepted item waits in the input register.
// The state update of an item happens when it moves from the
// input register into the result register, where its result becomes valid.
// Synchronous active-low reset clears the lock state: all threads idle, the
// tail on the extra node. A stalled result holds both registers; the input
// register still takes one item while it is empty.
module clh_queue_lock_manager_unit #(
    parameter int NUM_THREADS = clhq_pkg::NUM_THREADS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clhq_req_if.sink    i_req,
    clhq_res_if.source  o_res
);
    import clhq_pkg::*;

    logic                r_in_valid;
    t_req                r_req_type;
    logic [THREAD_W-1:0] r_req_thread;
    logic                r_out_valid;
    t_result             r_result;
    t_result             core_result;
    logic                advance;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_req_type   <= i_req.req_type;
            r_req_thread <= i_req.req_thread;
        end
        if (advance) begin
            r_result <= core_result;
        end
    end

    clhq_core #(
        .NUM_THREADS (NUM_THREADS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_req_type   (r_req_type),
        .i_req_thread (r_req_thread),
        .o_result     (core_result)
    );

    assign o_res.valid        = r_out_valid;
    assign o_res.grant_valid  = r_result.grant_valid;
    assign o_res.grant_thread = r_result.grant_thread;
    assign o_res.queued       = r_result.queued;
    assign o_res.misuse       = r_result.misuse;

endmodule

// ===== verif/clhq_lock_checker.sv =====
// Lock-state checker for the CLH queue lock manager: follows the request and result
// channels, predicts each result and counts mismatches for the testbench top.
// Depends on clhq_pkg.
`timescale 1ns / 1ps

module clhq_lock_checker
    import clhq_pkg::*;
#(
    parameter int NUM_THREADS = NUM_THREADS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    input  t_req                i_req_type,
    input  logic [THREAD_W-1:0] i_req_thread,
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  logic                i_grant_valid,
    input  logic [THREAD_W-1:0] i_grant_thread,
    input  logic                i_queued,
    input  logic                i_misuse,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int NODES  = NUM_THREADS + 1;
    localparam int NODE_W = $clog2(NODES);

    t_status             thread_state [NUM_THREADS];
    logic [NODE_W-1:0]   owned_node   [NUM_THREADS];
    logic [NODE_W-1:0]   pred_node    [NUM_THREADS];
    logic                node_set     [NODES];
    logic                waiter_on    [NODES];
    logic [THREAD_W-1:0] waiter_id    [NODES];
    logic [NODE_W-1:0]   tail;
    t_result             grants_due[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_result step_lock(input t_req kind, input logic [THREAD_W-1:0] tid);
        t_result           r;
        logic [NODE_W-1:0] mine;
        logic [NODE_W-1:0] prev;
        r = '0;
        if (int'(tid) >= NUM_THREADS) begin
            r.misuse = 1'b1;
        end else if (kind == REQ_ACQUIRE) begin
            if (thread_state[tid] != ST_IDLE) begin
                r.misuse = 1'b1;
            end else begin
                mine            = owned_node[tid];
                prev            = tail;
                node_set[mine]  = 1'b1;
                tail            = mine;
                pred_node[tid]  = prev;
                if (!node_set[prev]) begin
                    thread_state[tid] = ST_HOLD;
                    r.grant_valid     = 1'b1;
                    r.grant_thread    = tid;
                end else begin
                    waiter_on[prev]   = 1'b1;
                    waiter_id[prev]   = tid;
                    thread_state[tid] = ST_WAIT;
                    r.queued          = 1'b1;
                end
            end
        end else begin
            if (thread_state[tid] != ST_HOLD) begin
                r.misuse = 1'b1;
            end else begin
                mine              = owned_node[tid];
                node_set[mine]    = 1'b0;
                owned_node[tid]   = pred_node[tid];
                thread_state[tid] = ST_IDLE;
                // hand the lock to whoever was parked on the node just freed
                if (waiter_on[mine]) begin
                    waiter_on[mine]                  = 1'b0;
                    thread_state[waiter_id[mine]]    = ST_HOLD;
                    r.grant_valid                    = 1'b1;
                    r.grant_thread                   = waiter_id[mine];
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_THREADS; i++) begin
                thread_state[i] = ST_IDLE;
                owned_node[i]   = NODE_W'(i);
                pred_node[i]    = '0;
            end
            for (int i = 0; i < NODES; i++) begin
                node_set[i]  = 1'b0;
                waiter_on[i] = 1'b0;
                waiter_id[i] = '0;
            end
            tail = NODE_W'(NUM_THREADS);
            grants_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (grants_due.size() == 0) begin
                    $error("result with nothing pending: grant_valid %0d grant_thread %0d",
                           i_grant_valid, i_grant_thread);
                    o_fail_count++;
                end else begin
                    want = grants_due.pop_front();
                    if (i_grant_valid !== want.grant_valid) begin
                        $error("grant_valid: expected %0d, got %0d",
                               want.grant_valid, i_grant_valid);
                        o_fail_count++;
                    end
                    if (i_grant_thread !== want.grant_thread) begin
                        $error("grant_thread: expected %0d, got %0d",
                               want.grant_thread, i_grant_thread);
                        o_fail_count++;
                    end
                    if (i_queued !== want.queued) begin
                        $error("queued: expected %0d, got %0d", want.queued, i_queued);
                        o_fail_count++;
                    end
                    if (i_misuse !== want.misuse) begin
                        $error("misuse: expected %0d, got %0d", want.misuse, i_misuse);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                grants_due.push_back(step_lock(i_req_type, i_req_thread));
            end
        end
        o_pending = grants_due.size();
    end

endmodule

// ===== verif/clh_queue_lock_manager_unit_tb.sv =====
// Testbench top for clh_queue_lock_manager_unit: drives lock requests (directed misuse
// and hand-off cases, then mostly well-formed FIFO traffic) with random stalls.
// Depends on clhq_pkg, clhq_if.sv, the design and clhq_lock_checker.
`timescale 1ns / 1ps

module clh_queue_lock_manager_unit_tb;
    import clhq_pkg::*;

    localparam int NUM_THREADS     = NUM_THREADS_DEF;
    localparam int ITEMS           = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int QUIET_LIMIT     = 5000;

    logic i_clk;
    logic i_rst_n;

    clhq_req_if req_if ();
    clhq_res_if res_if ();

    int fail_count;
    int pending;

    // stimulus-side view of the lock queue, used only to shape legal traffic
    logic [THREAD_W-1:0]    lock_line[$];
    logic [NUM_THREADS-1:0] in_line;
    int served;
    int acquires;
    int releases;
    int deepest;
    int quiet_cycles;
    bit steady;
    bit hold_off_go;
    bit hold_off_done;

    clh_queue_lock_manager_unit #(
        .NUM_THREADS(NUM_THREADS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    clhq_lock_checker #(
        .NUM_THREADS(NUM_THREADS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_if.valid),
        .i_req_ready   (req_if.ready),
        .i_req_type    (req_if.req_type),
        .i_req_thread  (req_if.req_thread),
        .i_res_valid   (res_if.valid),
        .i_res_ready   (res_if.ready),
        .i_grant_valid (res_if.grant_valid),
        .i_grant_thread(res_if.grant_thread),
        .i_queued      (res_if.queued),
        .i_misuse      (res_if.misuse),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stalls, one long hold-off to back up the pipeline
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_go && !hold_off_done) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                hold_off_done = 1'b1;
            end else begin
                res_if.ready <= steady || ($urandom_range(99) >= 32);
            end
        end
    end

    task automatic issue(input t_req kind, input logic [THREAD_W-1:0] tid);
        if (kind == REQ_ACQUIRE && int'(tid) < NUM_THREADS && !in_line[tid]) begin
            lock_line.push_back(tid);
            in_line[tid] = 1'b1;
            acquires++;
            served++;
        end else if (kind == REQ_RELEASE && lock_line.size() > 0 && lock_line[0] == tid) begin
            lock_line.delete(0);
            in_line[tid] = 1'b0;
            releases++;
            served++;
        end
        if (lock_line.size() > deepest) deepest = lock_line.size();
        while (!steady && $urandom_range(99) < 32) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= kind;
        req_if.req_thread <= tid;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        logic [THREAD_W-1:0] tid;
        t_req                kind;
        int                  acquire_pct;
        int                  step;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.req_type   = REQ_ACQUIRE;
        req_if.req_thread = '0;
        in_line           = '0;
        served            = 0;
        acquires          = 0;
        releases          = 0;
        deepest           = 0;
        quiet_cycles      = 0;
        steady            = 1'b0;
        hold_off_go       = 1'b0;
        hold_off_done     = 1'b0;
        acquire_pct       = 50;
        step              = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        issue(REQ_RELEASE, 4'd5);   // release while idle
        issue(REQ_ACQUIRE, 4'd0);   // free lock, granted at once
        issue(REQ_ACQUIRE, 4'd0);   // acquire while holding
        issue(REQ_ACQUIRE, 4'd15);  // queued behind holder
        issue(REQ_ACQUIRE, 4'd15);  // acquire while waiting
        issue(REQ_RELEASE, 4'd15);  // release while waiting
        issue(REQ_ACQUIRE, 4'd7);
        issue(REQ_RELEASE, 4'd7);
        issue(REQ_RELEASE, 4'd0);   // hand-off to 15
        issue(REQ_RELEASE, 4'd15);  // hand-off to 7
        issue(REQ_RELEASE, 4'd7);   // release with nobody waiting
        issue(REQ_ACQUIRE, 4'd15);  // recycled nodes
        issue(REQ_ACQUIRE, 4'd0);
        issue(REQ_RELEASE, 4'd15);
        issue(REQ_RELEASE, 4'd0);

        while (served < ITEMS) begin
            if (step % 64 == 0) begin
                case ($urandom_range(2))
                    0: acquire_pct = 25;
                    1: acquire_pct = 50;
                    default: acquire_pct = 85;
                endcase
            end
            step++;
            steady = (served >= 900 && served < 1200);
            if (served >= 500) hold_off_go = 1'b1;
            if ($urandom_range(99) < 15) begin
                kind = t_req'($urandom_range(1));
                tid  = THREAD_W'($urandom_range(2**THREAD_W - 1));
            end else if (lock_line.size() == 0 ||
                         (lock_line.size() < NUM_THREADS && $urandom_range(99) < acquire_pct)) begin
                kind = REQ_ACQUIRE;
                do tid = THREAD_W'($urandom_range(NUM_THREADS - 1)); while (in_line[tid]);
            end else begin
                kind = REQ_RELEASE;
                tid  = lock_line[0];
            end
            issue(kind, tid);
        end
        req_if.valid <= 1'b0;
        steady = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d legal lock requests (%0d acquires, %0d releases) plus misuse",
                 served, acquires, releases);
        $display("Lock queue reached depth %0d of %0d; result side held off for %0d cycles",
                 deepest, NUM_THREADS, HOLD_OFF_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
